// File: design/bilevel_run_length_bitmap_decoder_macros.svh
// assertion macros used by the decoder back end
`ifndef BILEVEL_RUN_LENGTH_BITMAP_DECODER_MACROS_SVH
`define BILEVEL_RUN_LENGTH_BITMAP_DECODER_MACROS_SVH

// property checked on every clock edge out of reset
`define BRLD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never hold out of reset
`define BRLD_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: design/brld_pkg.sv
// types, codes and constants of the run-length bitmap decoder
`default_nettype none

package brld_pkg;

    localparam logic [7:0] HDR_ESC   = 8'h1b;
    localparam logic [7:0] HDR_G     = 8'h47;
    localparam logic [7:0] HDR_LARGE = 8'h48;
    localparam logic [7:0] HDR_SMALL = 8'h4d;
    localparam logic [7:0] RUN_BIAS  = 8'h20;
    localparam logic [7:0] RUN_TOP   = 8'h7f;

    localparam int SMALL_W = 128;
    localparam int SMALL_H = 96;
    localparam int LARGE_W = 256;
    localparam int LARGE_H = 192;

    localparam logic [15:0] PIX_SMALL = 16'(SMALL_W * SMALL_H);
    localparam logic [15:0] PIX_LARGE = 16'(LARGE_W * LARGE_H);

    localparam logic [1:0] HDR_POS_ESC  = 2'd0;
    localparam logic [1:0] HDR_POS_G    = 2'd1;
    localparam logic [1:0] HDR_POS_SIZE = 2'd2;
    localparam logic [1:0] HDR_POS_DONE = 2'd3;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD_HDR = 2'd1;
    localparam logic [1:0] STATUS_BAD_RUN = 2'd2;

    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_RUN     = 2'd1;
    localparam logic [1:0] OP_ERR_HDR = 2'd2;
    localparam logic [1:0] OP_ERR_RUN = 2'd3;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;

    typedef struct packed {
        logic [1:0] op;
        logic       size_large;
        logic [6:0] run;
    } cmd_t;

    typedef struct packed {
        logic push;
        cmd_t cmd;
    } push_t;

    typedef struct packed {
        logic empty;
        cmd_t head;
    } head_t;

endpackage

`default_nettype wire

// File: design/brld_in_if.sv
// channel carrying coded bytes into the decoder
`default_nettype none

interface brld_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       first_byte;

    modport source (output valid, output in_byte, output first_byte, input ready);
    modport sink (input valid, input in_byte, input first_byte, output ready);
endinterface

`default_nettype wire

// File: design/brld_out_if.sv
// channel carrying packed pixel bytes out of the decoder
`default_nettype none

interface brld_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_byte;
    logic       large_image;
    logic [1:0] status;
    logic       last;

    modport source (output valid, output pixel_byte, output large_image, output status,
                    output last, input ready);
    modport sink (input valid, input pixel_byte, input large_image, input status,
                  input last, output ready);
endinterface

`default_nettype wire

// File: design/brld_front.sv
// front end: header check and run byte classification into commands
`default_nettype none

module brld_front
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    brld_in_if.sink              coded,
    input  wire logic            q_full,
    output brld_pkg::push_t      push
);

    logic       idle_reg;
    logic       idle_next;
    logic [1:0] pos_reg;
    logic [1:0] pos_next;
    logic       accept;
    logic       eff_idle;
    logic [1:0] eff_pos;
    logic       hdr_ok;
    logic       run_ok;
    logic [7:0] b;

    assign coded.ready = !q_full;
    assign accept      = coded.valid && coded.ready;
    assign b           = coded.in_byte;
    assign eff_idle    = coded.first_byte ? 1'b0 : idle_reg;
    assign eff_pos     = coded.first_byte ? brld_pkg::HDR_POS_ESC : pos_reg;
    assign run_ok      = (b >= brld_pkg::RUN_BIAS) && (b <= brld_pkg::RUN_TOP);

    always_comb
    begin
        unique case (eff_pos)
            brld_pkg::HDR_POS_ESC:  hdr_ok = (b == brld_pkg::HDR_ESC);
            brld_pkg::HDR_POS_G:    hdr_ok = (b == brld_pkg::HDR_G);
            brld_pkg::HDR_POS_SIZE: hdr_ok = (b == brld_pkg::HDR_LARGE) ||
                                             (b == brld_pkg::HDR_SMALL);
            default:                hdr_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        idle_next           = idle_reg;
        pos_next            = pos_reg;
        push.push           = 1'b0;
        push.cmd.op         = brld_pkg::OP_RUN;
        push.cmd.size_large = (b == brld_pkg::HDR_LARGE);
        push.cmd.run        = 7'(b - brld_pkg::RUN_BIAS);
        if (accept)
        begin
            idle_next = eff_idle;
            pos_next  = eff_pos;
            if (!eff_idle)
            begin
                if (eff_pos != brld_pkg::HDR_POS_DONE)
                begin
                    if (hdr_ok)
                    begin
                        pos_next = eff_pos + 2'd1;
                        if (eff_pos == brld_pkg::HDR_POS_SIZE)
                        begin
                            push.push   = 1'b1;
                            push.cmd.op = brld_pkg::OP_START;
                        end
                    end
                    else
                    begin
                        push.push   = 1'b1;
                        push.cmd.op = brld_pkg::OP_ERR_HDR;
                        idle_next   = 1'b1;
                    end
                end
                else if (run_ok)
                begin
                    push.push   = 1'b1;
                    push.cmd.op = brld_pkg::OP_RUN;
                end
                else
                begin
                    push.push   = 1'b1;
                    push.cmd.op = brld_pkg::OP_ERR_RUN;
                    idle_next   = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_reg <= 1'b1;
            pos_reg  <= brld_pkg::HDR_POS_ESC;
        end
        else
        begin
            idle_reg <= idle_next;
            pos_reg  <= pos_next;
        end
    end

endmodule

`default_nettype wire

// File: design/brld_queue.sv
// two-entry command queue between front end and back end
`default_nettype none

module brld_queue
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire brld_pkg::push_t push,
    input  wire logic            pop,
    output logic                 full,
    output brld_pkg::head_t      head
);

    localparam int Q_AW = brld_pkg::Q_AW;
    localparam logic [Q_AW:0] DEPTH = (Q_AW + 1)'(brld_pkg::Q_DEPTH);

    brld_pkg::cmd_t      mem [brld_pkg::Q_DEPTH];
    logic [Q_AW-1:0]     wr_reg;
    logic [Q_AW-1:0]     rd_reg;
    logic [Q_AW:0]       count_reg;
    logic                do_push;
    logic                do_pop;

    assign full       = (count_reg == DEPTH);
    assign head.empty = (count_reg == '0);
    assign head.head  = mem[rd_reg];
    assign do_push    = push.push && !full;
    assign do_pop     = pop && !head.empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_reg] <= push.cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: design/brld_back.sv
// back end: expands runs into packed pixel bytes and drives the output register
`default_nettype none

`include "bilevel_run_length_bitmap_decoder_macros.svh"

module brld_back
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire brld_pkg::head_t head,
    output logic                 pop,
    brld_out_if.source           image
);

    logic        active_reg;
    logic        done_reg;
    logic        size_reg;
    logic        phase_reg;
    logic [15:0] pix_reg;
    logic [7:0]  acc_reg;
    logic [2:0]  fill_reg;
    logic [6:0]  run_reg;

    logic        out_valid_reg;
    logic [7:0]  out_pix_reg;
    logic        out_large_reg;
    logic [1:0]  out_status_reg;
    logic        out_last_reg;

    logic        out_free;
    logic [15:0] total;
    logic [15:0] remain;
    logic [15:0] run_w;
    logic [15:0] lim;
    logic [3:0]  room;
    logic [3:0]  chunk;
    logic [3:0]  fill_sum;
    logic        byte_full;
    logic [15:0] shifted;
    logic [15:0] ones;
    logic [7:0]  acc_new;
    logic [15:0] pix_new;
    logic [6:0]  run_new;
    logic        img_end;
    logic        step;
    logic        load;
    logic [7:0]  load_pix;
    logic        load_large;
    logic [1:0]  load_status;
    logic        load_last;

    assign out_free  = !out_valid_reg || image.ready;
    assign total     = size_reg ? brld_pkg::PIX_LARGE : brld_pkg::PIX_SMALL;
    assign remain    = total - pix_reg;
    assign run_w     = 16'(run_reg);
    assign lim       = (run_w < remain) ? run_w : remain;
    assign room      = 4'd8 - 4'(fill_reg);
    assign chunk     = (lim < 16'(room)) ? lim[3:0] : room;
    assign fill_sum  = 4'(fill_reg) + chunk;
    assign byte_full = fill_sum[3];
    assign shifted   = 16'(acc_reg) << chunk;
    assign ones      = (16'd1 << chunk) - 16'd1;
    assign acc_new   = phase_reg ? shifted[7:0] : (shifted[7:0] | ones[7:0]);
    assign pix_new   = pix_reg + 16'(chunk);
    assign run_new   = run_reg - 7'(chunk);
    assign img_end   = (pix_new == total);
    assign step      = active_reg && (!byte_full || out_free);
    assign pop       = !active_reg && !head.empty && out_free;

    always_comb
    begin
        load        = 1'b0;
        load_pix    = acc_new;
        load_large  = size_reg;
        load_status = brld_pkg::STATUS_OK;
        load_last   = img_end;
        if (step)
        begin
            load = byte_full;
        end
        else if (pop)
        begin
            unique case (head.head.op)
                brld_pkg::OP_ERR_HDR:
                begin
                    load        = 1'b1;
                    load_pix    = 8'd0;
                    load_large  = 1'b0;
                    load_status = brld_pkg::STATUS_BAD_HDR;
                    load_last   = 1'b1;
                end
                brld_pkg::OP_ERR_RUN:
                begin
                    load        = !done_reg;
                    load_pix    = 8'd0;
                    load_status = brld_pkg::STATUS_BAD_RUN;
                    load_last   = 1'b1;
                end
                default:
                begin
                    load = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b1;
            size_reg   <= 1'b0;
            phase_reg  <= 1'b0;
            pix_reg    <= '0;
            acc_reg    <= '0;
            fill_reg   <= '0;
            run_reg    <= '0;
        end
        else if (step)
        begin
            pix_reg <= pix_new;
            run_reg <= run_new;
            if (byte_full)
            begin
                acc_reg  <= '0;
                fill_reg <= '0;
            end
            else
            begin
                acc_reg  <= acc_new;
                fill_reg <= fill_sum[2:0];
            end
            if (img_end)
            begin
                active_reg <= 1'b0;
                done_reg   <= 1'b1;
            end
            else if (run_new == '0)
            begin
                active_reg <= 1'b0;
                phase_reg  <= !phase_reg;
            end
        end
        else if (pop)
        begin
            unique case (head.head.op)
                brld_pkg::OP_START:
                begin
                    done_reg  <= 1'b0;
                    size_reg  <= head.head.size_large;
                    phase_reg <= 1'b0;
                    pix_reg   <= '0;
                    acc_reg   <= '0;
                    fill_reg  <= '0;
                end
                brld_pkg::OP_RUN:
                begin
                    if (!done_reg)
                    begin
                        active_reg <= 1'b1;
                        run_reg    <= head.head.run;
                    end
                end
                brld_pkg::OP_ERR_HDR:
                begin
                    done_reg <= 1'b1;
                end
                default:
                begin
                    done_reg <= 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (image.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_pix_reg    <= load_pix;
            out_large_reg  <= load_large;
            out_status_reg <= load_status;
            out_last_reg   <= load_last;
        end
    end

    assign image.valid       = out_valid_reg;
    assign image.pixel_byte  = out_pix_reg;
    assign image.large_image = out_large_reg;
    assign image.status      = out_status_reg;
    assign image.last        = out_last_reg;

    `BRLD_ASSERT(a_pix_bound, pix_reg <= total, "pixel count past end of image")
    `BRLD_ASSERT(a_last_done, (load && load_last) |=> done_reg, "last item left decoder running")
    `BRLD_NEVER(a_run_when_done, active_reg && done_reg, "run active after image end")
    `BRLD_NEVER(a_load_busy, load && !out_free, "output register overwritten")

endmodule

`default_nettype wire

// File: design/bilevel_run_length_bitmap_decoder.sv
// top level of the bilevel run-length bitmap decoder
`default_nettype none

// Decodes a 1-bit-per-pixel run-length file one coded byte per item and returns packed
// pixel bytes, MSB first, white as 1. The front end takes a byte every cycle while the
// two-entry command queue has room. The back end pops a command when it is not
// expanding a run and the output register is free, and then expands a run in chunks of
// up to eight pixels, one chunk per cycle; the longest run is 95 pixels, and a full
// output register that is not drained stalls it. The final pixel byte of an image, and
// any error item, carries last. A bad header byte gives one error item, a bad run byte
// gives one unless the image is complete, and the decoder then waits for first_byte.
module bilevel_run_length_bitmap_decoder
(
    input  wire logic clk,
    input  wire logic rst_n,
    brld_in_if.sink   coded,
    brld_out_if.source image
);

    brld_pkg::push_t push;
    brld_pkg::head_t head;
    logic            q_full;
    logic            pop;

    brld_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .coded  (coded),
        .q_full (q_full),
        .push   (push)
    );

    brld_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (q_full),
        .head  (head)
    );

    brld_back u_back
    (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .image (image)
    );

endmodule

`default_nettype wire
